### rtl/core/ema_med_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ema_med_pkg
// Shared types and constants of the low-pass and median-of-window filter.
// ----------------------------------------------------------------------------
package ema_med_pkg;

  // Q2.14 sample and Q0.16 weight
  typedef logic signed [15:0] sample_t;
  typedef logic [15:0]        alpha_t;

  // Sliding window geometry
  localparam int WinLen = 5;
  localparam int FillW  = $clog2(WinLen + 1);
  localparam int PosW   = $clog2(WinLen);
  localparam int RankW  = $clog2(WinLen);

  // Low-pass weight after reset, about 0.1
  localparam alpha_t AlphaReset = 16'd6554;

endpackage
`default_nettype wire

### rtl/core/ema_and_median5_filter_top.sv
`default_nettype none
// Path: an accepted sample passes the input register, then the result register.
// Throughput: one sample per cycle while the output is not stalled; the
// low-pass multiply-add feeds back through the previous-value register and
// the window rank compare feeds the ring.
// Reset: previous low-pass value, window fill and write slot clear to zero, weight
// returns to 6554; window storage and result values are not cleared.
// ----------------------------------------------------------------------------
// ema_and_median5_filter_top
// Exponential low-pass and sliding-window median: an input register, one
// short combinational pass, and a result register.
// ----------------------------------------------------------------------------
module ema_and_median5_filter_top (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_wr_en,
  input  wire ema_med_pkg::alpha_t  cfg_wr_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire ema_med_pkg::sample_t sample,
  output logic                      out_valid,
  input  wire                       out_ready,
  output ema_med_pkg::sample_t      lowpass_value,
  output ema_med_pkg::sample_t      median_value
);

  localparam int WinLen = ema_med_pkg::WinLen;
  localparam int FillW  = ema_med_pkg::FillW;
  localparam int PosW   = ema_med_pkg::PosW;
  localparam int RankW  = ema_med_pkg::RankW;

  // Registers
  ema_med_pkg::alpha_t  alpha;
  ema_med_pkg::sample_t held_sample;
  logic                 held_valid;
  ema_med_pkg::sample_t prev;
  logic [FillW-1:0]     fill;
  logic [PosW-1:0]      wr_pos;
  ema_med_pkg::sample_t win [WinLen];

  // Next values and pass logic
  logic                 advance;
  logic signed [16:0]   diff;
  logic signed [33:0]   prod;
  logic signed [33:0]   prod_sh;
  logic [17:0]          lp_sum;
  ema_med_pkg::sample_t lowpass_next;
  logic [FillW-1:0]     fill_next;
  logic [PosW-1:0]      wr_pos_next;
  ema_med_pkg::sample_t win_new [WinLen];
  logic [WinLen-1:0]    vld_new;
  logic [RankW-1:0]     rank [WinLen];
  logic [FillW-1:0]     target;
  ema_med_pkg::sample_t median_next;

  // Handshake: move the held beat on when the result register is free
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ema_med_pkg::AlphaReset;
    end else if (cfg_wr_en) begin
      alpha <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_sample <= sample;
    end
  end

  // Low-pass: prev + floor(alpha * (sample - prev) / 2^16)
  assign diff         = {held_sample[15], held_sample} - {prev[15], prev};
  assign prod         = $signed({1'b0, alpha}) * diff;
  assign prod_sh      = prod >>> 16;
  assign lp_sum       = {{2{prev[15]}}, prev} + prod_sh[17:0];
  assign lowpass_next = lp_sum[15:0];

  // Window bookkeeping
  assign fill_next   = (fill < FillW'(WinLen)) ? fill + FillW'(1) : fill;
  assign wr_pos_next = (wr_pos == PosW'(WinLen - 1)) ? '0 : wr_pos + PosW'(1);
  assign target      = fill_next >> 1;

  // Window as it stands with the new sample written in
  always_comb begin
    for (int k = 0; k < WinLen; k++) begin
      win_new[k] = (wr_pos == PosW'(k)) ? held_sample : win[k];
      vld_new[k] = FillW'(k) < fill_next;
    end
  end

  // Rank each entry: count valid entries that sort ahead of it, ties by slot
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WinLen; j++) begin
        if (j != i && vld_new[j] &&
            (!vld_new[i] || win_new[j] < win_new[i] ||
             (win_new[j] == win_new[i] && j < i))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
    end
  end

  // Pick the valid entry whose rank is half the fill
  always_comb begin
    median_next = win_new[0];
    for (int k = 0; k < WinLen; k++) begin
      if (vld_new[k] && FillW'(rank[k]) == target) begin
        median_next = win_new[k];
      end
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev   <= '0;
      fill   <= '0;
      wr_pos <= '0;
    end else if (advance) begin
      prev   <= lowpass_next;
      fill   <= fill_next;
      wr_pos <= wr_pos_next;
    end
  end

  // Window ring, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      win[wr_pos] <= held_sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lowpass_value <= lowpass_next;
      median_value  <= median_next;
    end
  end

  // Checks

  // While filling, the ring write slot tracks the fill count
  a_pos_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FillW'(WinLen)) |-> (FillW'(wr_pos) == fill))
    else $error("write slot out of step with window fill");

  // Each advanced beat grows a partial window by one
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (advance && fill != FillW'(WinLen)) |=> (fill == $past(fill) + FillW'(1)))
    else $error("window fill did not grow");

  // A held beat that cannot move stays held
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !advance) |=> (held_valid && held_sample == $past(held_sample)))
    else $error("held beat lost while stalled");

  // Low-pass step never overshoots the sample
  a_lp_bounded: assert property (@(posedge clk) disable iff (rst)
    advance |->
      ((held_sample >= prev && lowpass_next >= prev && lowpass_next <= held_sample) ||
       (held_sample <  prev && lowpass_next <= prev && lowpass_next >= held_sample)))
    else $error("low-pass step passed the sample");

endmodule
`default_nettype wire
